// File: rtl/stpc_pkg.sv
// Shared constants, codes and types for the two-point sensor calibration core.
// No dependencies; used by stpc_div and the top-level core.
package stpc_pkg;

  localparam int GAIN_Q = 12;
  localparam int DIV_W  = 8 + GAIN_Q;
  localparam int CNT_W  = $clog2(DIV_W + 1);

  localparam logic [15:0] GAIN_RESET = 16'(1 << (GAIN_Q - 8));
  localparam logic [15:0] GAIN_MIN   = 16'h003f;
  localparam logic [15:0] GAIN_MAX   = 16'hffff;
  localparam logic [7:0]  TEMP_MAX   = 8'd255;

  localparam logic [7:0]  MIN_TEMP_DIFF_RESET   = 8'd5;
  localparam logic [15:0] MIN_SIGNAL_DIFF_RESET = 16'd16;

  localparam logic CFG_MIN_TEMP_DIFF   = 1'b0;
  localparam logic CFG_MIN_SIGNAL_DIFF = 1'b1;

  typedef enum logic [1:0] {
    OP_CONVERT  = 2'd0,
    OP_CAL_ZERO = 2'd1,
    OP_CAL_GAIN = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_FIRST   = 3'd1;
  localparam logic [2:0] ST_FALL_RISE  = 3'd2;
  localparam logic [2:0] ST_RISE_FALL  = 3'd3;
  localparam logic [2:0] ST_TEMP_GAP   = 3'd4;
  localparam logic [2:0] ST_SIGNAL_GAP = 3'd5;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [15:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/stpc_if.sv
// Channel interfaces: input items and result items, valid/ready handshake.
// Depends on nothing.
interface stpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] signal;
  logic [7:0]  target_temp;

  modport source (output valid, op, signal, target_temp, input ready);
  modport sink   (input valid, op, signal, target_temp, output ready);
endinterface

interface stpc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  temperature;
  logic        low_over;
  logic        high_over;
  logic [2:0]  status;
  logic [15:0] gain_now;
  logic [15:0] zero_now;

  modport source (output valid, temperature, low_over, high_over, status, gain_now, zero_now,
                  input ready);
  modport sink   (input valid, temperature, low_over, high_over, status, gain_now, zero_now,
                  output ready);
endinterface

// File: rtl/stpc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on stpc_pkg.
module stpc_div (
  input  logic               clk,
  input  logic               rst,
  input  stpc_pkg::div_req_t req,
  output stpc_pkg::div_rsp_t rsp
);

  logic                         busy;
  logic                         done;
  logic [stpc_pkg::CNT_W-1:0]   cnt;
  logic [15:0]                  rem;
  logic [15:0]                  dsr;
  logic [stpc_pkg::DIV_W-1:0]   quo;
  logic [16:0]                  rem_shift;
  logic                         ge;
  logic [16:0]                  rem_next;

  assign rem_shift = {rem, quo[stpc_pkg::DIV_W-1]};
  assign ge        = rem_shift >= {1'b0, dsr};
  assign rem_next  = ge ? rem_shift - {1'b0, dsr} : rem_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= stpc_pkg::CNT_W'(stpc_pkg::DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == stpc_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= rem_next[15:0];
      quo <= {quo[stpc_pkg::DIV_W-2:0], ge};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: rtl/sensor_two_point_calibration_core.sv
// Top level: calibration state, sequencer, convert multiplier and result register.
// Depends on stpc_pkg, stpc_if (stpc_in_if, stpc_out_if) and stpc_div.
//
//   channel   dir  handshake      payload
//   in_item   in   valid/ready    op, signal, target_temp
//   out_item  out  valid/ready    temperature, low_over, high_over, status, gain_now, zero_now
//   cfg       in   cfg_we         cfg_index, cfg_data
//
// Convert: one 16x16 multiply, then range check.
// Calibrate: up to three divisions on the shared divider, one after another.
// One transaction in flight; in_item.ready is high only while the sequencer is idle,
// and a finished result waits in the output register while the next item is taken.
// rst is synchronous and clears the sequencer, configuration, calibration state and out_item.valid.
module sensor_two_point_calibration_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  stpc_in_if.sink           in_item,
  stpc_out_if.source        out_item
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_EVAL      = 10'b0000000010,
    S_CUR_WAIT  = 10'b0000000100,
    S_CHECK     = 10'b0000001000,
    S_GAIN_WAIT = 10'b0000010000,
    S_ZERO_GO   = 10'b0000100000,
    S_ZERO_WAIT = 10'b0001000000,
    S_MUL       = 10'b0010000000,
    S_CONV      = 10'b0100000000,
    S_DONE      = 10'b1000000000
  } state_t;

  state_t      state;

  logic [7:0]  min_temp_diff;
  logic [15:0] min_signal_diff;

  logic [15:0] zero_point;
  logic [15:0] gain_value;
  logic [7:0]  last_temp;
  logic        low_flag;
  logic        high_flag;
  logic        first_point_done;
  logic [7:0]  prev_cal_temp;
  logic [15:0] prev_cal_signal;

  stpc_pkg::op_t op;
  logic [15:0] smp;
  logic [7:0]  tgt;
  logic [15:0] cur;
  logic [2:0]  status;
  logic [31:0] prod;
  logic        below;

  stpc_pkg::div_req_t div_req;
  stpc_pkg::div_rsp_t div_rsp;

  logic [7:0]  tdiff;
  logic [15:0] sdiff;
  logic [2:0]  check_status;
  logic [stpc_pkg::DIV_W-1:0] q;
  logic [15:0] gain_clamped;

  stpc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign q = div_rsp.quotient;

  always_comb begin
    check_status = stpc_pkg::ST_OK;
    if (prev_cal_temp > tgt) begin
      tdiff = prev_cal_temp - tgt;
      sdiff = prev_cal_signal - cur;
      if (prev_cal_signal < cur) check_status = stpc_pkg::ST_FALL_RISE;
    end else begin
      tdiff = tgt - prev_cal_temp;
      sdiff = cur - prev_cal_signal;
      if (cur < prev_cal_signal) check_status = stpc_pkg::ST_RISE_FALL;
    end
    if (check_status == stpc_pkg::ST_OK) begin
      if (tdiff < min_temp_diff) begin
        check_status = stpc_pkg::ST_TEMP_GAP;
      end else if (sdiff < min_signal_diff || sdiff == 16'd0) begin
        check_status = stpc_pkg::ST_SIGNAL_GAP;
      end
    end
  end

  always_comb begin
    if (q > stpc_pkg::DIV_W'(stpc_pkg::GAIN_MAX)) begin
      gain_clamped = stpc_pkg::GAIN_MAX;
    end else if (q < stpc_pkg::DIV_W'(stpc_pkg::GAIN_MIN)) begin
      gain_clamped = stpc_pkg::GAIN_MIN;
    end else begin
      gain_clamped = q[15:0];
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {tgt, {stpc_pkg::GAIN_Q{1'b0}}};
    div_req.divisor  = gain_value;
    case (state)
      S_EVAL: begin
        if ((op == stpc_pkg::OP_CAL_ZERO || (op == stpc_pkg::OP_CAL_GAIN && first_point_done))
            && (low_flag || high_flag)) begin
          div_req.start    = 1'b1;
          div_req.dividend = {last_temp, {stpc_pkg::GAIN_Q{1'b0}}};
        end
      end
      S_CHECK: begin
        if (op == stpc_pkg::OP_CAL_GAIN && check_status == stpc_pkg::ST_OK) begin
          div_req.start    = 1'b1;
          div_req.dividend = {tdiff, {stpc_pkg::GAIN_Q{1'b0}}};
          div_req.divisor  = sdiff;
        end
      end
      S_ZERO_GO: div_req.start = 1'b1;
      default: ;
    endcase
  end

  assign in_item.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      min_temp_diff    <= stpc_pkg::MIN_TEMP_DIFF_RESET;
      min_signal_diff  <= stpc_pkg::MIN_SIGNAL_DIFF_RESET;
      zero_point       <= '0;
      gain_value       <= stpc_pkg::GAIN_RESET;
      last_temp        <= '0;
      low_flag         <= 1'b0;
      high_flag        <= 1'b0;
      first_point_done <= 1'b0;
      prev_cal_temp    <= '0;
      prev_cal_signal  <= '0;
      out_item.valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          stpc_pkg::CFG_MIN_TEMP_DIFF:   min_temp_diff   <= cfg_data[7:0];
          stpc_pkg::CFG_MIN_SIGNAL_DIFF: min_signal_diff <= cfg_data;
          default: ;
        endcase
      end
      if (out_item.valid && out_item.ready && state != S_DONE) out_item.valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_item.valid) state <= S_EVAL;
        end
        S_EVAL: begin
          case (op)
            stpc_pkg::OP_CONVERT: state <= S_MUL;
            stpc_pkg::OP_CAL_ZERO, stpc_pkg::OP_CAL_GAIN: begin
              if (op == stpc_pkg::OP_CAL_GAIN && !first_point_done) begin
                state <= S_DONE;
              end else if (low_flag || high_flag) begin
                state <= S_CUR_WAIT;
              end else begin
                state <= S_CHECK;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_CUR_WAIT: begin
          if (div_rsp.done) state <= S_CHECK;
        end
        S_CHECK: begin
          if (op != stpc_pkg::OP_CAL_GAIN) begin
            state <= S_ZERO_GO;
          end else if (check_status == stpc_pkg::ST_OK) begin
            state <= S_GAIN_WAIT;
          end else begin
            state <= S_DONE;
          end
        end
        S_GAIN_WAIT: begin
          if (div_rsp.done) begin
            gain_value <= gain_clamped;
            state      <= S_ZERO_GO;
          end
        end
        S_ZERO_GO: state <= S_ZERO_WAIT;
        S_ZERO_WAIT: begin
          if (div_rsp.done) begin
            zero_point       <= cur - q[15:0];
            prev_cal_temp    <= tgt;
            prev_cal_signal  <= cur;
            first_point_done <= 1'b1;
            state            <= S_DONE;
          end
        end
        S_MUL: state <= S_CONV;
        S_CONV: begin
          if (below) begin
            last_temp <= '0;
            low_flag  <= 1'b1;
          end else if ((prod >> (stpc_pkg::GAIN_Q + 8)) != 32'd0) begin
            last_temp <= stpc_pkg::TEMP_MAX;
            high_flag <= 1'b1;
          end else begin
            last_temp <= 8'(prod >> stpc_pkg::GAIN_Q);
            low_flag  <= 1'b0;
            high_flag <= 1'b0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_item.valid || out_item.ready) begin
            out_item.valid <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op     <= stpc_pkg::op_t'(in_item.op);
        smp    <= in_item.signal;
        tgt    <= in_item.target_temp;
        status <= stpc_pkg::ST_OK;
      end
      S_EVAL: begin
        cur <= smp;
        if (op == stpc_pkg::OP_CAL_GAIN && !first_point_done) status <= stpc_pkg::ST_NO_FIRST;
      end
      S_CUR_WAIT: begin
        if (div_rsp.done) cur <= q[15:0] + zero_point;
      end
      S_CHECK: status <= (op == stpc_pkg::OP_CAL_GAIN) ? check_status : stpc_pkg::ST_OK;
      S_MUL: begin
        below <= smp < zero_point;
        prod  <= 32'(smp - zero_point) * 32'(gain_value);
      end
      S_DONE: begin
        if (!out_item.valid || out_item.ready) begin
          out_item.temperature <= last_temp;
          out_item.low_over    <= low_flag;
          out_item.high_over   <= high_flag;
          out_item.status      <= status;
          out_item.gain_now    <= gain_value;
          out_item.zero_now    <= zero_point;
        end
      end
      default: ;
    endcase
  end

endmodule
